FILE: rtl/rcm_pkg.sv
// Shared types and constants for the rectangle coordinate mapper.
// Holds the beat structs, register map, action codes and datapath widths.
// No dependencies.
package rcm_pkg;

    localparam int FIELD_W = 16;
    localparam int DEN_W   = 16;
    // signed offset of a coordinate from its rectangle origin
    localparam int N_W     = 18;
    // |offset * extent| + extent/2
    localparam int MAG_W   = N_W - 1 + DEN_W + 1;
    // signed value ahead of saturation
    localparam int VAL_W   = MAG_W + 2;
    localparam int LANES   = 4;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int OR_SWAP     = 0;
    localparam int OR_MIRROR_X = 1;
    localparam int OR_MIRROR_Y = 2;

    typedef enum logic [1:0] {
        ACT_MAP_PT,
        ACT_UNMAP_PT,
        ACT_MAP_RECT,
        ACT_UNMAP_RECT
    } action_t;

    typedef enum logic [2:0] {
        REG_FROM_MIN,
        REG_FROM_MAX,
        REG_TO_MIN,
        REG_TO_MAX,
        REG_ORIENT
    } reg_idx_t;

    typedef struct packed {
        action_t                    action;
        logic signed [FIELD_W-1:0]  in_x;
        logic signed [FIELD_W-1:0]  in_y;
        logic signed [FIELD_W-1:0]  in_x2;
        logic signed [FIELD_W-1:0]  in_y2;
    } in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  out_x;
        logic signed [FIELD_W-1:0]  out_y;
        logic signed [FIELD_W-1:0]  out_x2;
        logic signed [FIELD_W-1:0]  out_y2;
        logic                       bad_rect;
    } out_t;

    typedef struct packed {
        logic [DATA_W-1:0] from_min;
        logic [DATA_W-1:0] from_max;
        logic [DATA_W-1:0] to_min;
        logic [DATA_W-1:0] to_max;
        logic [2:0]        orient;
    } cfg_t;

    typedef struct packed {
        logic unmap;
        logic rect;
        logic bad;
    } ctrl_t;

    localparam cfg_t CFG_RST = '{
        from_min: 32'h0000_0000,
        from_max: 32'h0001_0001,
        to_min:   32'h0000_0000,
        to_max:   32'h0001_0001,
        orient:   3'd0
    };

    function automatic logic signed [FIELD_W-1:0] lo_half(input logic [DATA_W-1:0] r);
        return $signed(r[FIELD_W-1:0]);
    endfunction

    function automatic logic signed [FIELD_W-1:0] hi_half(input logic [DATA_W-1:0] r);
        return $signed(r[DATA_W-1:FIELD_W]);
    endfunction

endpackage

FILE: rtl/rcm_front.sv
// Front end of the mapper: action decode, swap and mirror, multiply, rounding bias.
// Three register stages feeding the divider lanes. Depends on rcm_pkg.
module rcm_front
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             en,
    input  logic                                             in_valid,
    input  rcm_pkg::in_t                                     req,
    input  rcm_pkg::cfg_t                                    cfg,
    output logic                                             out_valid,
    output rcm_pkg::ctrl_t                                   ctrl,
    output logic [rcm_pkg::LANES-1:0][rcm_pkg::MAG_W-1:0]    dividend,
    output logic [1:0][rcm_pkg::DEN_W-1:0]                   den,
    output logic [rcm_pkg::LANES-1:0]                        neg
);

    localparam int FW    = rcm_pkg::FIELD_W;
    localparam int NW    = rcm_pkg::N_W;
    localparam int DW    = rcm_pkg::DEN_W;
    localparam int MW    = rcm_pkg::MAG_W;
    localparam int LN    = rcm_pkg::LANES;

    // stage 1: offsets from origin, extents
    logic                   s1_valid_reg;
    rcm_pkg::ctrl_t         s1_ctrl_reg, s1_ctrl_next;
    logic signed [NW-1:0]   s1_n_reg [LN];
    logic signed [NW-1:0]   s1_n_next [LN];
    logic [DW-1:0]          s1_num_reg [2];
    logic [DW-1:0]          s1_num_next [2];
    logic [DW-1:0]          s1_den_reg [2];
    logic [DW-1:0]          s1_den_next [2];

    // stage 2: product magnitude
    logic                   s2_valid_reg;
    rcm_pkg::ctrl_t         s2_ctrl_reg;
    logic [MW-2:0]          s2_prod_reg [LN];
    logic [MW-2:0]          s2_prod_next [LN];
    logic [LN-1:0]          s2_neg_reg, s2_neg_next;
    logic [DW-1:0]          s2_den_reg [2];

    // stage 3: biased dividend
    logic                   s3_valid_reg;
    rcm_pkg::ctrl_t         s3_ctrl_reg;
    logic [LN-1:0][MW-1:0]  s3_dvd_reg, s3_dvd_next;
    logic [LN-1:0]          s3_neg_reg;
    logic [DW-1:0]          s3_den_reg [2];

    always_comb
    begin
        logic signed [FW-1:0] fx0, fy0, fx1, fy1, tx0, ty0, tx1, ty1;
        logic [DW:0]          fw_d, fh_d, tw_d, th_d;
        logic signed [FW-1:0] px, py, sx, sy;
        logic signed [NW-1:0] mx, my;
        fx0 = rcm_pkg::lo_half(cfg.from_min);
        fy0 = rcm_pkg::hi_half(cfg.from_min);
        fx1 = rcm_pkg::lo_half(cfg.from_max);
        fy1 = rcm_pkg::hi_half(cfg.from_max);
        tx0 = rcm_pkg::lo_half(cfg.to_min);
        ty0 = rcm_pkg::hi_half(cfg.to_min);
        tx1 = rcm_pkg::lo_half(cfg.to_max);
        ty1 = rcm_pkg::hi_half(cfg.to_max);
        fw_d = $unsigned((DW+1)'(fx1) - (DW+1)'(fx0));
        fh_d = $unsigned((DW+1)'(fy1) - (DW+1)'(fy0));
        tw_d = $unsigned((DW+1)'(tx1) - (DW+1)'(tx0));
        th_d = $unsigned((DW+1)'(ty1) - (DW+1)'(ty0));

        s1_ctrl_next.bad = (fx0 >= fx1) || (fy0 >= fy1) || (tx0 >= tx1) || (ty0 >= ty1);
        unique case (req.action)
            rcm_pkg::ACT_MAP_PT:     begin s1_ctrl_next.unmap = 1'b0; s1_ctrl_next.rect = 1'b0; end
            rcm_pkg::ACT_UNMAP_PT:   begin s1_ctrl_next.unmap = 1'b1; s1_ctrl_next.rect = 1'b0; end
            rcm_pkg::ACT_MAP_RECT:   begin s1_ctrl_next.unmap = 1'b0; s1_ctrl_next.rect = 1'b1; end
            rcm_pkg::ACT_UNMAP_RECT: begin s1_ctrl_next.unmap = 1'b1; s1_ctrl_next.rect = 1'b1; end
        endcase

        // x lanes scale by width ratio, y lanes by height ratio
        s1_num_next[0] = s1_ctrl_next.unmap ? fw_d[DW-1:0] : tw_d[DW-1:0];
        s1_den_next[0] = s1_ctrl_next.unmap ? tw_d[DW-1:0] : fw_d[DW-1:0];
        s1_num_next[1] = s1_ctrl_next.unmap ? fh_d[DW-1:0] : th_d[DW-1:0];
        s1_den_next[1] = s1_ctrl_next.unmap ? th_d[DW-1:0] : fh_d[DW-1:0];

        for (int p = 0; p < 2; p++)
        begin
            px = (p == 0) ? $signed(req.in_x) : $signed(req.in_x2);
            py = (p == 0) ? $signed(req.in_y) : $signed(req.in_y2);
            sx = cfg.orient[rcm_pkg::OR_SWAP] ? py : px;
            sy = cfg.orient[rcm_pkg::OR_SWAP] ? px : py;
            mx = cfg.orient[rcm_pkg::OR_MIRROR_X] ?
                 NW'(fx0) + NW'(fx1) - NW'(sx) : NW'(sx);
            my = cfg.orient[rcm_pkg::OR_MIRROR_Y] ?
                 NW'(fy0) + NW'(fy1) - NW'(sy) : NW'(sy);
            if (s1_ctrl_next.unmap)
            begin
                s1_n_next[2*p]   = NW'(px) - NW'(tx0);
                s1_n_next[2*p+1] = NW'(py) - NW'(ty0);
            end
            else
            begin
                s1_n_next[2*p]   = mx - NW'(fx0);
                s1_n_next[2*p+1] = my - NW'(fy0);
            end
        end
    end

    always_comb
    begin
        logic [NW-1:0] mag;
        for (int l = 0; l < LN; l++)
        begin
            s2_neg_next[l]  = s1_n_reg[l][NW-1];
            mag             = s2_neg_next[l] ? $unsigned(-s1_n_reg[l]) : $unsigned(s1_n_reg[l]);
            s2_prod_next[l] = mag[NW-2:0] * s1_num_reg[l%2];
        end
    end

    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            s3_dvd_next[l] = {1'b0, s2_prod_reg[l]} + MW'(s2_den_reg[l%2] >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s1_n_reg    <= s1_n_next;
            s1_num_reg  <= s1_num_next;
            s1_den_reg  <= s1_den_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_prod_reg <= s2_prod_next;
            s2_neg_reg  <= s2_neg_next;
            s2_den_reg  <= s1_den_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
            s3_dvd_reg  <= s3_dvd_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_den_reg  <= s2_den_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign ctrl      = s3_ctrl_reg;
    assign dividend  = s3_dvd_reg;
    assign neg       = s3_neg_reg;
    assign den[0]    = s3_den_reg[0];
    assign den[1]    = s3_den_reg[1];

endmodule

FILE: rtl/rcm_div.sv
// Pipelined restoring divider lane, one quotient bit per register stage.
// Carries a side tag alongside the quotient. Depends on rcm_pkg.
module rcm_div
#(
    parameter int TAG_W = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rcm_pkg::MAG_W-1:0]   dividend,
    input  logic [rcm_pkg::DEN_W-1:0]   den,
    input  logic [TAG_W-1:0]            tag_in,
    output logic                        out_valid,
    output logic [rcm_pkg::MAG_W-1:0]   quotient,
    output logic [TAG_W-1:0]            tag_out
);

    localparam int MW  = rcm_pkg::MAG_W;
    localparam int DW  = rcm_pkg::DEN_W;
    localparam int NST = rcm_pkg::MAG_W;

    logic               vld_reg  [NST];
    logic [MW-1:0]      dq_reg   [NST];
    logic [TAG_W-1:0]   tag_reg  [NST];
    logic [DW-1:0]      rem_reg  [NST-1];
    logic [DW-1:0]      den_reg  [NST-1];

    logic [MW-1:0]      src_dq   [NST];
    logic [DW-1:0]      src_rem  [NST];
    logic [DW-1:0]      src_den  [NST];
    logic [DW:0]        trial    [NST];
    logic [DW:0]        diff     [NST];
    logic               ge       [NST];
    logic [MW-1:0]      dq_next  [NST];
    logic [DW-1:0]      rem_next [NST-1];

    always_comb
    begin
        src_dq[0]  = dividend;
        src_rem[0] = '0;
        src_den[0] = den;
        for (int i = 1; i < NST; i++)
        begin
            src_dq[i]  = dq_reg[i-1];
            src_rem[i] = rem_reg[i-1];
            src_den[i] = den_reg[i-1];
        end
        // shift in the next dividend bit, quotient bit enters at the bottom
        for (int i = 0; i < NST; i++)
        begin
            trial[i]   = {src_rem[i], src_dq[i][MW-1]};
            diff[i]    = trial[i] - {1'b0, src_den[i]};
            ge[i]      = trial[i] >= {1'b0, src_den[i]};
            dq_next[i] = {src_dq[i][MW-2:0], ge[i]};
        end
        for (int i = 0; i < NST-1; i++)
        begin
            rem_next[i] = ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 0; i < NST; i++)
            begin
                dq_reg[i] <= dq_next[i];
            end
            for (int i = 1; i < NST; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
            for (int i = 0; i < NST-1; i++)
            begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= src_den[i];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign quotient  = dq_reg[NST-1];
    assign tag_out   = tag_reg[NST-1];

endmodule

FILE: rtl/rcm_back.sv
// Back end of the mapper: sign and translate, unmap mirror and swap, saturate,
// reorder rectangle corners. Three register stages. Depends on rcm_pkg.
module rcm_back
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             en,
    input  logic                                             in_valid,
    input  rcm_pkg::ctrl_t                                   ctrl,
    input  logic [rcm_pkg::LANES-1:0][rcm_pkg::MAG_W-1:0]    quotient,
    input  logic [rcm_pkg::LANES-1:0]                        neg,
    input  rcm_pkg::cfg_t                                    cfg,
    output logic                                             out_valid,
    output rcm_pkg::out_t                                    rsp
);

    localparam int FW = rcm_pkg::FIELD_W;
    localparam int MW = rcm_pkg::MAG_W;
    localparam int VW = rcm_pkg::VAL_W;
    localparam int LN = rcm_pkg::LANES;
    localparam logic signed [VW-1:0] SAT_HI = VW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;

    logic                   b1_valid_reg;
    rcm_pkg::ctrl_t         b1_ctrl_reg;
    logic signed [VW-1:0]   b1_v_reg  [LN];
    logic signed [VW-1:0]   b1_v_next [LN];

    logic                   b2_valid_reg;
    rcm_pkg::ctrl_t         b2_ctrl_reg;
    logic signed [VW-1:0]   b2_r_reg  [LN];
    logic signed [VW-1:0]   b2_r_next [LN];

    logic                   b3_valid_reg;
    rcm_pkg::out_t          b3_rsp_reg, b3_rsp_next;

    function automatic logic signed [VW-1:0] sat(input logic signed [VW-1:0] v);
        if (v > SAT_HI)
        begin
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            return SAT_LO;
        end
        return v;
    endfunction

    always_comb
    begin
        logic signed [FW-1:0] off;
        logic signed [VW-1:0] qs;
        for (int l = 0; l < LN; l++)
        begin
            if (ctrl.unmap)
            begin
                off = (l % 2 == 0) ? rcm_pkg::lo_half(cfg.from_min)
                                   : rcm_pkg::hi_half(cfg.from_min);
            end
            else
            begin
                off = (l % 2 == 0) ? rcm_pkg::lo_half(cfg.to_min)
                                   : rcm_pkg::hi_half(cfg.to_min);
            end
            qs           = $signed({{(VW-MW){1'b0}}, quotient[l]});
            b1_v_next[l] = neg[l] ? VW'(off) - qs : VW'(off) + qs;
        end
    end

    always_comb
    begin
        logic signed [VW-1:0] vx, vy, fxs, fys;
        fxs = VW'(rcm_pkg::lo_half(cfg.from_min)) + VW'(rcm_pkg::lo_half(cfg.from_max));
        fys = VW'(rcm_pkg::hi_half(cfg.from_min)) + VW'(rcm_pkg::hi_half(cfg.from_max));
        for (int p = 0; p < 2; p++)
        begin
            vx = b1_v_reg[2*p];
            vy = b1_v_reg[2*p+1];
            if (b1_ctrl_reg.unmap)
            begin
                if (cfg.orient[rcm_pkg::OR_MIRROR_X])
                begin
                    vx = fxs - vx;
                end
                if (cfg.orient[rcm_pkg::OR_MIRROR_Y])
                begin
                    vy = fys - vy;
                end
                if (cfg.orient[rcm_pkg::OR_SWAP])
                begin
                    b2_r_next[2*p]   = sat(vy);
                    b2_r_next[2*p+1] = sat(vx);
                end
                else
                begin
                    b2_r_next[2*p]   = sat(vx);
                    b2_r_next[2*p+1] = sat(vy);
                end
            end
            else
            begin
                b2_r_next[2*p]   = sat(vx);
                b2_r_next[2*p+1] = sat(vy);
            end
        end
    end

    always_comb
    begin
        logic signed [VW-1:0] x0, y0, x1, y1;
        x0 = b2_r_reg[0];
        y0 = b2_r_reg[1];
        x1 = '0;
        y1 = '0;
        if (b2_ctrl_reg.rect)
        begin
            // order the corners so min never exceeds max
            x0 = (b2_r_reg[0] > b2_r_reg[2]) ? b2_r_reg[2] : b2_r_reg[0];
            x1 = (b2_r_reg[0] > b2_r_reg[2]) ? b2_r_reg[0] : b2_r_reg[2];
            y0 = (b2_r_reg[1] > b2_r_reg[3]) ? b2_r_reg[3] : b2_r_reg[1];
            y1 = (b2_r_reg[1] > b2_r_reg[3]) ? b2_r_reg[1] : b2_r_reg[3];
        end
        if (b2_ctrl_reg.bad)
        begin
            x0 = '0;
            y0 = '0;
            x1 = '0;
            y1 = '0;
        end
        b3_rsp_next.out_x    = x0[FW-1:0];
        b3_rsp_next.out_y    = y0[FW-1:0];
        b3_rsp_next.out_x2   = x1[FW-1:0];
        b3_rsp_next.out_y2   = y1[FW-1:0];
        b3_rsp_next.bad_rect = b2_ctrl_reg.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_ctrl_reg <= ctrl;
            b1_v_reg    <= b1_v_next;
            b2_ctrl_reg <= b1_ctrl_reg;
            b2_r_reg    <= b2_r_next;
            b3_rsp_reg  <= b3_rsp_next;
        end
    end

    assign out_valid = b3_valid_reg;
    assign rsp       = b3_rsp_reg;

endmodule

FILE: rtl/rcm_obuf.sv
// Two-entry output buffer that decouples the pipeline from the result channel.
// Depends on rcm_pkg.
module rcm_obuf
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rcm_pkg::out_t   data,
    output logic            full,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rcm_pkg::out_t   rsp
);

    localparam logic [1:0] DEPTH = 2'd2;

    logic [1:0]     cnt_reg, cnt_next;
    rcm_pkg::out_t  head_reg, head_next;
    rcm_pkg::out_t  tail_reg, tail_next;
    logic           pop;

    assign pop       = rsp_valid && rsp_ready;
    assign rsp_valid = cnt_reg != 2'd0;
    assign full      = cnt_reg == DEPTH;
    assign rsp       = head_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push && pop)
        begin
            if (cnt_reg == 2'd1)
            begin
                head_next = data;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = data;
            end
        end
        else if (push)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd0)
            begin
                head_next = data;
            end
            else
            begin
                tail_next = data;
            end
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

FILE: rtl/rect_coordinate_mapper.sv
// Rectangle coordinate mapper, top level: register port, front end, four
// divider lanes, back end and output buffer. Depends on all rcm_ files but rcm_check.
//
// Maps or unmaps a point or a rectangle between a source and a destination
// rectangle under a swap/mirror orientation code. One request beat is taken
// every clock unless the pipeline holds; each result passes through 3 front
// stages, 34 divider stages of one quotient bit each and 3 back stages, then
// sits in a two-entry output buffer. The whole pipeline holds while that buffer
// is full and a finished beat waits at its entry. Registers sit at byte
// addresses 0, 4, 8, 12 and 16 and must only be written while no request is in
// flight. COORD_BITS sets the signed range results saturate to.
module rect_coordinate_mapper
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcm_pkg::ADDR_W-1:0]      paddr,
    input  logic [rcm_pkg::DATA_W-1:0]      pwdata,
    output logic [rcm_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  rcm_pkg::in_t                    req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output rcm_pkg::out_t                   rsp
);

    localparam int LN  = rcm_pkg::LANES;
    localparam int MW  = rcm_pkg::MAG_W;
    localparam int DW  = rcm_pkg::DEN_W;
    localparam int CTW = $bits(rcm_pkg::ctrl_t);

    rcm_pkg::cfg_t          cfg_reg, cfg_next;
    rcm_pkg::reg_idx_t      reg_idx;
    logic                   wr_en;

    logic                   en;
    logic                   front_valid;
    rcm_pkg::ctrl_t         front_ctrl;
    logic [LN-1:0][MW-1:0]  front_dvd;
    logic [1:0][DW-1:0]     front_den;
    logic [LN-1:0]          front_neg;

    logic                   div_valid;
    logic [LN-1:0][MW-1:0]  div_q;
    logic [LN-1:0]          div_neg;
    rcm_pkg::ctrl_t         div_ctrl;

    logic                   back_valid;
    rcm_pkg::out_t          back_rsp;
    logic                   obuf_full;

    assign pready  = 1'b1;
    assign reg_idx = rcm_pkg::reg_idx_t'(paddr[rcm_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_idx)
            rcm_pkg::REG_FROM_MIN:
            begin
                prdata = cfg_reg.from_min;
                cfg_next.from_min = pwdata;
            end
            rcm_pkg::REG_FROM_MAX:
            begin
                prdata = cfg_reg.from_max;
                cfg_next.from_max = pwdata;
            end
            rcm_pkg::REG_TO_MIN:
            begin
                prdata = cfg_reg.to_min;
                cfg_next.to_min = pwdata;
            end
            rcm_pkg::REG_TO_MAX:
            begin
                prdata = cfg_reg.to_max;
                cfg_next.to_max = pwdata;
            end
            rcm_pkg::REG_ORIENT:
            begin
                prdata = {{(rcm_pkg::DATA_W-3){1'b0}}, cfg_reg.orient};
                cfg_next.orient = pwdata[2:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rcm_pkg::CFG_RST;
        end
        else if (wr_en)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // advance unless a finished beat has nowhere to go
    assign en        = !back_valid || !obuf_full;
    assign req_ready = en;

    rcm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .req       (req),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .ctrl      (front_ctrl),
        .dividend  (front_dvd),
        .den       (front_den),
        .neg       (front_neg)
    );

    rcm_div #(.TAG_W(CTW + 1)) u_div0
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .dividend  (front_dvd[0]),
        .den       (front_den[0]),
        .tag_in    ({front_ctrl, front_neg[0]}),
        .out_valid (div_valid),
        .quotient  (div_q[0]),
        .tag_out   ({div_ctrl, div_neg[0]})
    );

    for (genvar l = 1; l < LN; l++)
    begin : g_lane
        rcm_div #(.TAG_W(1)) u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (front_valid),
            .dividend  (front_dvd[l]),
            .den       (front_den[l%2]),
            .tag_in    (front_neg[l]),
            .out_valid (),
            .quotient  (div_q[l]),
            .tag_out   (div_neg[l])
        );
    end

    rcm_back #(.COORD_BITS(COORD_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .ctrl      (div_ctrl),
        .quotient  (div_q),
        .neg       (div_neg),
        .cfg       (cfg_reg),
        .out_valid (back_valid),
        .rsp       (back_rsp)
    );

    rcm_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (back_valid && en),
        .data      (back_rsp),
        .full      (obuf_full),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/rcm_check.sv
// Port-level checker for the rectangle coordinate mapper, bound to the top level.
// Depends on rcm_pkg and rect_coordinate_mapper.
module rcm_check
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  rcm_pkg::out_t   rsp
);

    // pipeline registers plus the two-entry output buffer
    localparam int MAX_INFLIGHT = rcm_pkg::MAG_W + 8;

    logic [6:0] cnt_reg, cnt_next;
    logic       req_beat, rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (req_beat && !rsp_beat)
        begin
            cnt_next = cnt_reg + 7'd1;
        end
        else if (rsp_beat && !req_beat)
        begin
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.bad_rect |->
            rsp.out_x == 0 && rsp.out_y == 0 && rsp.out_x2 == 0 && rsp.out_y2 == 0)
        else $error("empty rectangle result carries nonzero coordinates");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result beat dropped or changed");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_beat |-> cnt_reg != 7'd0)
        else $error("result beat without an outstanding request");

    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(MAX_INFLIGHT))
        else $error("more requests in flight than the pipeline holds");

endmodule

bind rect_coordinate_mapper rcm_check u_rcm_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

FILE: test/rect_coordinate_mapper_test.sv
// Self-checking bench for rect_coordinate_mapper: random and directed point and
// rectangle beats under several register settings, checked against an in-bench model.
// Depends on rcm_pkg and the rect_coordinate_mapper RTL.
module rect_coordinate_mapper_test;

    localparam int LATENCY   = 40;
    localparam int MAX_CYCLE = 1000000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [rcm_pkg::ADDR_W-1:0] paddr;
    logic [rcm_pkg::DATA_W-1:0] pwdata;
    logic [rcm_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic req_valid, req_ready;
    rcm_pkg::in_t req;
    logic rsp_valid, rsp_ready;
    rcm_pkg::out_t rsp;

    rect_coordinate_mapper dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    logic [31:0] cur_from_min, cur_from_max, cur_to_min, cur_to_max;
    logic [2:0] cur_orient;

    rcm_pkg::in_t pending_beats[$];
    rcm_pkg::out_t expected_results[$];
    int errors;
    int cycle_count;
    int send_gap;
    int recv_stall;
    logic req_ready_seen;
    logic gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint lo16(logic [31:0] r);
        return longint'($signed(r[15:0]));
    endfunction

    function automatic longint hi16(logic [31:0] r);
        return longint'($signed(r[31:16]));
    endfunction

    // half away from zero; den and num nonzero, same sign expected but handle any
    function automatic longint scale_round(longint n, longint num, longint den);
        longint t;
        t = n * num;
        if (t >= 0)
            return (den / 2 + t) / den;
        return -((den / 2 - t) / den);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int pick_gap();
        int p;
        if (!gaps_on)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic map_coord(input logic unmap, input longint x, input longint y,
                             output longint ox, output longint oy);
        longint fx0, fy0, fx1, fy1, tx0, ty0, tx1, ty1, mx, my, t;
        fx0 = lo16(cur_from_min); fy0 = hi16(cur_from_min);
        fx1 = lo16(cur_from_max); fy1 = hi16(cur_from_max);
        tx0 = lo16(cur_to_min);   ty0 = hi16(cur_to_min);
        tx1 = lo16(cur_to_max);   ty1 = hi16(cur_to_max);
        if (!unmap)
        begin
            mx = x;
            my = y;
            if (cur_orient[rcm_pkg::OR_SWAP]) begin t = mx; mx = my; my = t; end
            if (cur_orient[rcm_pkg::OR_MIRROR_X]) mx = fx0 + fx1 - mx;
            if (cur_orient[rcm_pkg::OR_MIRROR_Y]) my = fy0 + fy1 - my;
            ox = clamp_coord(tx0 + scale_round(mx - fx0, tx1 - tx0, fx1 - fx0));
            oy = clamp_coord(ty0 + scale_round(my - fy0, ty1 - ty0, fy1 - fy0));
        end
        else
        begin
            mx = fx0 + scale_round(x - tx0, fx1 - fx0, tx1 - tx0);
            my = fy0 + scale_round(y - ty0, fy1 - fy0, ty1 - ty0);
            if (cur_orient[rcm_pkg::OR_MIRROR_X]) mx = fx0 + fx1 - mx;
            if (cur_orient[rcm_pkg::OR_MIRROR_Y]) my = fy0 + fy1 - my;
            if (cur_orient[rcm_pkg::OR_SWAP]) begin t = mx; mx = my; my = t; end
            ox = clamp_coord(mx);
            oy = clamp_coord(my);
        end
    endtask

    task automatic predict_mapping(input rcm_pkg::in_t b);
        rcm_pkg::out_t r;
        longint a0, a1, a2, a3, t;
        logic unmap;
        r = '0;
        unmap = (b.action == rcm_pkg::ACT_UNMAP_PT) || (b.action == rcm_pkg::ACT_UNMAP_RECT);
        if (lo16(cur_from_min) >= lo16(cur_from_max) || hi16(cur_from_min) >= hi16(cur_from_max)
            || lo16(cur_to_min) >= lo16(cur_to_max) || hi16(cur_to_min) >= hi16(cur_to_max))
        begin
            r.bad_rect = 1'b1;
        end
        else
        begin
            map_coord(unmap, longint'(b.in_x), longint'(b.in_y), a0, a1);
            a2 = 0;
            a3 = 0;
            if (b.action == rcm_pkg::ACT_MAP_RECT || b.action == rcm_pkg::ACT_UNMAP_RECT)
            begin
                map_coord(unmap, longint'(b.in_x2), longint'(b.in_y2), a2, a3);
                if (a0 > a2) begin t = a0; a0 = a2; a2 = t; end
                if (a1 > a3) begin t = a1; a1 = a3; a3 = t; end
            end
            r.out_x = a0[15:0];
            r.out_y = a1[15:0];
            r.out_x2 = a2[15:0];
            r.out_y2 = a3[15:0];
        end
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        errors++;
    endtask

    // driver: payload changes only at the falling edge; hold a beat until accepted
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_ready_seen)
            begin
                req_valid <= 1'b1;
            end
            else if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_beats.size() > 0)
            begin
                req <= pending_beats.pop_front();
                req_valid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
            begin
                req_valid <= 1'b0;
            end
            if (recv_stall > 0)
            begin
                rsp_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                rsp_ready <= 1'b1;
                recv_stall <= pick_gap();
            end
        end
    end

    // track acceptance of the request beat and the result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            req_ready_seen <= req_valid && req_ready;
            if (req_valid && req_ready)
                predict_mapping(req);
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected beat", rsp.out_x, 16'h0);
                end
                else
                begin
                    rcm_pkg::out_t w;
                    w = expected_results.pop_front();
                    if (rsp.out_x !== w.out_x) report_mismatch("out_x", rsp.out_x, w.out_x);
                    if (rsp.out_y !== w.out_y) report_mismatch("out_y", rsp.out_y, w.out_y);
                    if (rsp.out_x2 !== w.out_x2)
                        report_mismatch("out_x2", rsp.out_x2, w.out_x2);
                    if (rsp.out_y2 !== w.out_y2)
                        report_mismatch("out_y2", rsp.out_y2, w.out_y2);
                    if (rsp.bad_rect !== w.bad_rect)
                        report_mismatch("bad_rect", 16'(rsp.bad_rect), 16'(w.bad_rect));
                end
            end
            if (cycle_count > MAX_CYCLE)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input rcm_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rcm_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rcm_pkg::REG_FROM_MIN: cur_from_min = value;
            rcm_pkg::REG_FROM_MAX: cur_from_max = value;
            rcm_pkg::REG_TO_MIN:   cur_to_min = value;
            rcm_pkg::REG_TO_MAX:   cur_to_max = value;
            default:               cur_orient = value[2:0];
        endcase
    endtask

    task automatic drain_pipeline();
        while (pending_beats.size() > 0 || req_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] corner(int x, int y);
        return {16'(y), 16'(x)};
    endfunction

    function automatic rcm_pkg::in_t random_beat(int lo, int hi);
        rcm_pkg::in_t b;
        b.action = rcm_pkg::action_t'($urandom_range(0, 3));
        b.in_x = 16'($urandom_range(0, hi - lo) + lo);
        b.in_y = 16'($urandom_range(0, hi - lo) + lo);
        b.in_x2 = 16'($urandom_range(0, hi - lo) + lo);
        b.in_y2 = 16'($urandom_range(0, hi - lo) + lo);
        if ($urandom_range(0, 9) == 0)
            b = {b.action, 64'($urandom()) << 32 | 64'($urandom())};
        return b;
    endfunction

    task automatic random_setting();
        int x0, y0;
        x0 = $urandom_range(0, 2000) - 1000;
        y0 = $urandom_range(0, 2000) - 1000;
        write_reg(rcm_pkg::REG_FROM_MIN, corner(x0, y0));
        write_reg(rcm_pkg::REG_FROM_MAX,
                  corner(x0 + $urandom_range(1, 800), y0 + $urandom_range(1, 800)));
        x0 = $urandom_range(0, 2000) - 1000;
        y0 = $urandom_range(0, 2000) - 1000;
        write_reg(rcm_pkg::REG_TO_MIN, corner(x0, y0));
        write_reg(rcm_pkg::REG_TO_MAX,
                  corner(x0 + $urandom_range(1, 800), y0 + $urandom_range(1, 800)));
        write_reg(rcm_pkg::REG_ORIENT, 32'($urandom_range(0, 7)));
    endtask

    initial
    begin
        rcm_pkg::in_t b;
        errors = 0;
        cycle_count = 0;
        send_gap = 0;
        recv_stall = 0;
        gaps_on = 1'b0;
        req_ready_seen = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_valid = 1'b0; req = '0; rsp_ready = 1'b0;
        cur_from_min = rcm_pkg::CFG_RST.from_min;
        cur_from_max = rcm_pkg::CFG_RST.from_max;
        cur_to_min = rcm_pkg::CFG_RST.to_min;
        cur_to_max = rcm_pkg::CFG_RST.to_max;
        cur_orient = rcm_pkg::CFG_RST.orient;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset setting, every action, field extremes
        for (int a = 0; a < 4; a++)
        begin
            pending_beats.push_back('{rcm_pkg::action_t'(a), 16'sh7fff, -16'sh8000,
                                      -16'sh8000, 16'sh7fff});
            pending_beats.push_back('{rcm_pkg::action_t'(a), 16'sd0, 16'sd1, 16'sd1, 16'sd0});
        end
        drain_pipeline();

        // extreme rectangles: full span, saturation, swap + both mirrors
        write_reg(rcm_pkg::REG_FROM_MIN, corner(-32768, -32768));
        write_reg(rcm_pkg::REG_FROM_MAX, corner(32767, 32767));
        write_reg(rcm_pkg::REG_TO_MIN, corner(0, 0));
        write_reg(rcm_pkg::REG_TO_MAX, corner(3, 1));
        write_reg(rcm_pkg::REG_ORIENT, 32'd7);
        for (int a = 0; a < 4; a++)
        begin
            pending_beats.push_back('{rcm_pkg::action_t'(a), 16'sh7fff, -16'sh8000,
                                      16'sd5, -16'sd5});
            pending_beats.push_back('{rcm_pkg::action_t'(a), 16'sd2, 16'sd2, 16'sd2, 16'sd2});
        end
        drain_pipeline();

        // empty source, then empty destination
        write_reg(rcm_pkg::REG_FROM_MAX, corner(-32768, 100));
        pending_beats.push_back('{rcm_pkg::ACT_MAP_RECT, 16'sd1, 16'sd2, 16'sd3, 16'sd4});
        pending_beats.push_back('{rcm_pkg::ACT_UNMAP_PT, 16'sd1, 16'sd2, 16'sd3, 16'sd4});
        drain_pipeline();
        write_reg(rcm_pkg::REG_FROM_MAX, corner(100, 100));
        write_reg(rcm_pkg::REG_TO_MAX, corner(3, 0));
        pending_beats.push_back('{rcm_pkg::ACT_MAP_PT, 16'sd1, 16'sd2, 16'sd3, 16'sd4});
        pending_beats.push_back('{rcm_pkg::ACT_UNMAP_RECT, 16'sd1, 16'sd2, 16'sd3, 16'sd4});
        drain_pipeline();

        // random phases; first phase without idling
        for (int ph = 0; ph < 12; ph++)
        begin
            random_setting();
            gaps_on = (ph != 0);
            for (int i = 0; i < 120; i++)
            begin
                b = random_beat(-1500, 1500);
                pending_beats.push_back(b);
            end
            drain_pipeline();
        end

        while (expected_results.size() > 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
